FILE: hdl/prrt_pkg.sv
// shared types and constants of the page range reservation table
package prrt_pkg;

    localparam int PAGE_W = 36;
    localparam int CNT_W = 20;
    localparam int GSH_W = 5;
    localparam logic [GSH_W-1:0] GSH_MAX = 5'd20;
    localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

    // request kinds
    typedef enum logic [1:0] {
        OP_RSV_AT  = 2'd0,
        OP_RSV_ANY = 2'd1,
        OP_CHECK   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // result codes
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_OUTSIDE  = 3'd1,
        STAT_OVERLAP  = 3'd2,
        STAT_NO_SPACE = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_ZERO     = 3'd5
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REGION_START = 2'd0,
        CFG_REGION_END   = 2'd1,
        CFG_WM_START     = 2'd2,
        CFG_GRAN_SHIFT   = 2'd3
    } cfg_reg_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_CHECK  = 4'd1,
        S_SCAN   = 4'd2,
        S_EVAL   = 4'd3,
        S_DIFF   = 4'd4,
        S_STEP   = 4'd5,
        S_RECORD = 4'd6,
        S_RESP   = 4'd7
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    scan_clear;
        logic    scan_run;
        logic    target_load;
        logic    target_start;
        logic    diff_load;
        logic    cand_step;
        logic    record;
        logic    wm_bump;
        logic    wm_cand;
        logic    out_load;
        logic    out_acc;
        logic    out_res_cand;
        status_t out_status;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic zero_cnt;
        logic below_start;
        logic at_end;
        logic table_full;
        logic scan_done;
        logic pipe_busy;
        logic overlap;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hdl/prrt_ctrl.sv
// controller state machine of the page range reservation table
module prrt_ctrl import prrt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    acc_reg, acc_next;
    logic    res_cand_reg, res_cand_next;

    // state and held result code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg <= STAT_OK;
            acc_reg <= 1'b0;
            res_cand_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg <= st_next;
            acc_reg <= acc_next;
            res_cand_reg <= res_cand_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        st_next = st_reg;
        acc_next = acc_reg;
        res_cand_next = res_cand_reg;
        s_tready = 1'b0;
        cmd = '0;
        cmd.out_status = st_reg;
        cmd.out_acc = acc_reg;
        cmd.out_res_cand = res_cand_reg;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                st_next = STAT_OK;
                acc_next = 1'b0;
                res_cand_next = 1'b0;
                case (stat.op)
                    OP_RSV_AT: begin
                        if (stat.zero_cnt) begin
                            st_next = STAT_ZERO;
                            state_next = S_RESP;
                        end else if (stat.below_start || stat.at_end) begin
                            st_next = STAT_OUTSIDE;
                            state_next = S_RESP;
                        end else begin
                            cmd.scan_clear = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    OP_RSV_ANY: begin
                        if (stat.zero_cnt) begin
                            st_next = STAT_ZERO;
                            state_next = S_RESP;
                        end else if (stat.table_full) begin
                            st_next = STAT_FULL;
                            state_next = S_RESP;
                        end else if (stat.at_end) begin
                            // search ran off the region: keep candidate as watermark
                            cmd.wm_cand = 1'b1;
                            st_next = STAT_NO_SPACE;
                            state_next = S_RESP;
                        end else if (stat.below_start) begin
                            cmd.target_load = 1'b1;
                            cmd.target_start = 1'b1;
                            state_next = S_DIFF;
                        end else begin
                            cmd.scan_clear = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    OP_CHECK: begin
                        if (stat.below_start || stat.at_end) begin
                            st_next = STAT_OUTSIDE;
                            state_next = S_RESP;
                        end else begin
                            cmd.scan_clear = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done && !stat.pipe_busy) begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                case (stat.op)
                    OP_RSV_AT: begin
                        if (stat.overlap) begin
                            st_next = STAT_OVERLAP;
                            state_next = S_RESP;
                        end else if (stat.table_full) begin
                            st_next = STAT_FULL;
                            state_next = S_RESP;
                        end else begin
                            acc_next = 1'b1;
                            res_cand_next = 1'b1;
                            state_next = S_RECORD;
                        end
                    end
                    OP_RSV_ANY: begin
                        if (stat.overlap) begin
                            // skip past the furthest overlapping range
                            cmd.target_load = 1'b1;
                            state_next = S_DIFF;
                        end else begin
                            acc_next = 1'b1;
                            res_cand_next = 1'b1;
                            state_next = S_RECORD;
                        end
                    end
                    OP_CHECK: begin
                        acc_next = stat.overlap;
                        state_next = S_RESP;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next = S_STEP;
            end

            S_STEP: begin
                cmd.cand_step = 1'b1;
                state_next = S_CHECK;
            end

            S_RECORD: begin
                cmd.record = 1'b1;
                cmd.wm_bump = (stat.op == OP_RSV_ANY);
                state_next = S_RESP;
            end

            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/prrt_datapath.sv
// datapath: configuration, watermark, range table memory, scan and output word
module prrt_datapath import prrt_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [PAGE_W-1:0]   cfg_data,
    input  logic [1:0]          s_tuser,
    input  logic [55:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          stat
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] USED_MAX = CW'(MAX_ENTRIES);
    localparam int ENT_W = PAGE_W + CNT_W;

    // configuration and watermark
    logic [PAGE_W-1:0] start_reg, end_reg, wm_reg;
    logic [GSH_W-1:0]  gshift_reg;

    // item
    op_t               op_reg;
    logic [CNT_W-1:0]  cnt_reg, len_reg;
    logic [PAGE_W-1:0] cand_reg;
    logic [PAGE_W:0]   hi_reg;
    logic [CNT_W:0]    rnd_reg;
    logic [PAGE_W-1:0] target_reg;
    logic [PAGE_W:0]   diff_reg;

    // table and scan
    logic [ENT_W-1:0]  entry_mem [MAX_ENTRIES];
    logic [CW-1:0]     used_reg, idx_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    logic              v1_reg, v2_reg;
    logic [PAGE_W:0]   e2_reg;
    logic [PAGE_W-1:0] b2_reg;
    logic [PAGE_W:0]   best_reg;

    // output word
    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg;

    logic [GSH_W-1:0]  gsh;
    logic [CNT_W-1:0]  gmask;
    logic              issue, hit;
    logic [PAGE_W+1:0] step_sum;
    logic [PAGE_W:0]   bump_sum;
    logic [PAGE_W:0]   diff_masked;
    logic [PAGE_W-1:0] in_page;
    logic [CNT_W-1:0]  in_cnt;
    op_t               in_op;

    assign in_page = s_tdata[PAGE_W-1:0];
    assign in_cnt = s_tdata[PAGE_W+CNT_W-1:PAGE_W];
    assign in_op = op_t'(s_tuser);

    // granularity mask, shift capped at twenty
    assign gsh = (gshift_reg > GSH_MAX) ? GSH_MAX : gshift_reg;
    assign gmask = ~({CNT_W{1'b1}} << gsh);

    // configuration writes; the watermark start goes straight to the watermark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg <= PAGE_MAX;
            gshift_reg <= 5'd4;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_REGION_START: start_reg <= cfg_data;
                CFG_REGION_END:   end_reg <= cfg_data;
                CFG_GRAN_SHIFT:   gshift_reg <= cfg_data[GSH_W-1:0];
                default: ;
            endcase
        end
    end

    // watermark: loaded by config, moved by reserve-any
    assign bump_sum = {1'b0, cand_reg} + {{(PAGE_W-CNT_W){1'b0}}, rnd_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm_reg <= '0;
        end else if (cfg_valid && cfg_reg_t'(cfg_index) == CFG_WM_START) begin
            wm_reg <= cfg_data;
        end else if (cmd.wm_cand) begin
            wm_reg <= cand_reg;
        end else if (cmd.wm_bump) begin
            wm_reg <= bump_sum[PAGE_W] ? PAGE_MAX : bump_sum[PAGE_W-1:0];
        end
    end

    // candidate search arithmetic
    assign diff_masked = diff_reg & ~{{(PAGE_W+1-CNT_W){1'b0}}, gmask};
    assign step_sum = {2'b00, cand_reg} + {1'b0, diff_masked};

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg <= in_op;
            cnt_reg <= in_cnt;
            len_reg <= (in_op == OP_CHECK) ? CNT_W'(1) : in_cnt;
            cand_reg <= (in_op == OP_RSV_ANY) ? wm_reg : in_page;
        end else if (cmd.cand_step) begin
            cand_reg <= (step_sum > {2'b00, PAGE_MAX}) ? PAGE_MAX : step_sum[PAGE_W-1:0];
        end
        hi_reg <= {1'b0, cand_reg} + {{(PAGE_W+1-CNT_W){1'b0}}, len_reg};
        rnd_reg <= ({1'b0, cnt_reg} + {1'b0, gmask}) & ~{1'b0, gmask};
        if (cmd.target_load) begin
            if (cmd.target_start) begin
                target_reg <= (start_reg < end_reg) ? start_reg : end_reg;
            end else begin
                target_reg <= (best_reg < {1'b0, end_reg}) ? best_reg[PAGE_W-1:0] : end_reg;
            end
        end
        if (cmd.diff_load) begin
            diff_reg <= {1'b0, target_reg} - {1'b0, cand_reg}
                        + {{(PAGE_W+1-CNT_W){1'b0}}, gmask};
        end
    end

    // fill count of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.record && used_reg != USED_MAX) begin
            used_reg <= used_reg + CW'(1);
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.record && used_reg != USED_MAX) begin
            entry_mem[used_reg[AW-1:0]] <= {len_reg, cand_reg};
        end
        if (issue) begin
            rd_data_reg <= entry_mem[idx_reg[AW-1:0]];
        end
    end

    // scan address and pipeline valids
    assign issue = cmd.scan_run && (idx_reg < used_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (cmd.scan_clear) begin
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // range end of the entry read
    always_ff @(posedge aclk) begin
        e2_reg <= {1'b0, rd_data_reg[PAGE_W-1:0]}
                  + {{(PAGE_W+1-CNT_W){1'b0}}, rd_data_reg[ENT_W-1:PAGE_W]};
        b2_reg <= rd_data_reg[PAGE_W-1:0];
    end

    // half-open overlap test and largest overlapping end
    assign hit = ({1'b0, cand_reg} < e2_reg) && ({1'b0, b2_reg} < hi_reg);
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            best_reg <= '0;
        end else if (v2_reg && hit && e2_reg > best_reg) begin
            best_reg <= e2_reg;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {cmd.out_status,
                            cmd.out_res_cand ? cand_reg : {PAGE_W{1'b0}},
                            cmd.out_acc};
        end
    end
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    // status to controller
    always_comb begin
        stat.op = op_reg;
        stat.zero_cnt = (cnt_reg == '0);
        stat.below_start = (cand_reg < start_reg);
        stat.at_end = (cand_reg >= end_reg);
        stat.table_full = (used_reg == USED_MAX);
        stat.scan_done = !(idx_reg < used_reg);
        stat.pipe_busy = v1_reg || v2_reg;
        stat.overlap = (best_reg != '0);
        stat.out_busy = m_tvalid_reg && !m_tready;
    end

endmodule

FILE: hdl/page_range_reservation_table.sv
// top level of the page range reservation table
// flow: accept in idle, check, scan of every used entry, evaluate, record, then the result word
// check requests and overlaps skip the record step; requests refused in the check skip the scan
// reserve-any: a skip past an overlap or jump into the region runs diff, step and a new check
// throughput: one request in work at a time; the next is taken while its result word waits
// reset: registers to their defaults, watermark 0, table empty; no clearing pass
module page_range_reservation_table import prrt_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [35:0] cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // page[35:0], page_count[55:36]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // accepted[0], result_page[36:1], status[39:37]
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    prrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prrt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
